@@ design/qmr_pkg.sv @@
// Shared constants, codes and types for the queue with move-to-rear.
package qmr_pkg;

  // Queue depth and the widths that follow from it.
  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the request and result ports.
  localparam int DATA_W = 32;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Width used when comparing a position against the element count.
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // One request to the write and read ports of the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // A finished result, handed to the output register.
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

endpackage

@@ design/qmr_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
module qmr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/qmr_ctrl.sv @@
// Sequencer that keeps the circular queue pointers and drives the entry memory.
module qmr_ctrl import qmr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  cmd_e              command_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] rdata_i,
  output mem_req_t          mem_req_o,
  output result_t           result_o,
  output logic              busy_o
);

  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DEQ   = 5'b00010,
    S_MVRD  = 5'b00100,
    S_SHIFT = 5'b01000,
    S_MVWR  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    wr_off_q, wr_off_d;
  logic [DATA_W-1:0]   moved_q, moved_d;
  logic [CMP_W-1:0]    pos_cmp;
  logic [CMP_W-1:0]    cnt_cmp;

  // Physical slot of the entry at a given offset from the front.
  function automatic logic [ADDR_W-1:0] phys(input logic [ADDR_W-1:0] head,
                                             input logic [CNT_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

  assign pos_cmp = CMP_W'(position_i);
  assign cnt_cmp = CMP_W'(count_q);

  // Next-state logic and memory accesses.
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    wr_off_d  = wr_off_q;
    moved_d   = moved_q;
    mem_req_o = '0;
    result_o  = '0;
    result_o.status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (accept_i) begin
          case (command_i)
            CMD_ENQ: begin
              result_o.valid = 1'b1;
              if (count_q == CNT_W'(DEPTH)) begin
                result_o.status = ST_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = phys(head_q, count_q);
                mem_req_o.wdata = value_i;
                count_d         = count_q + CNT_W'(1);
              end
            end
            CMD_DEQ: begin
              if (count_q == '0) begin
                result_o.valid  = 1'b1;
                result_o.status = ST_EMPTY;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = head_q;
                state_d         = S_DEQ;
              end
            end
            CMD_MOVE: begin
              if (pos_cmp == '0 || pos_cmp > cnt_cmp) begin
                result_o.valid  = 1'b1;
                result_o.status = ST_RANGE;
              end else if (pos_cmp == cnt_cmp) begin
                // The rear element is already in place.
                result_o.valid = 1'b1;
              end else begin
                wr_off_d        = CNT_W'(pos_cmp - CMP_W'(1));
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = phys(head_q, wr_off_d);
                state_d         = S_MVRD;
              end
            end
            default: begin
              result_o.valid = 1'b1;
            end
          endcase
        end
      end
      S_DEQ: begin
        result_o.valid = 1'b1;
        result_o.data  = rdata_i;
        head_d         = phys(head_q, CNT_W'(1));
        count_d        = count_q - CNT_W'(1);
        state_d        = S_IDLE;
      end
      S_MVRD: begin
        // Hold the element being moved and fetch its successor.
        moved_d         = rdata_i;
        mem_req_o.re    = 1'b1;
        mem_req_o.raddr = phys(head_q, wr_off_q + CNT_W'(1));
        state_d         = S_SHIFT;
      end
      S_SHIFT: begin
        // Write back one slot lower while the next successor, if any, is read.
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = phys(head_q, wr_off_q);
        mem_req_o.wdata = rdata_i;
        if (wr_off_q + CNT_W'(2) < count_q) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = phys(head_q, wr_off_q + CNT_W'(2));
        end else begin
          state_d = S_MVWR;
        end
        wr_off_d = wr_off_q + CNT_W'(1);
      end
      S_MVWR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = phys(head_q, count_q - CNT_W'(1));
        mem_req_o.wdata = moved_q;
        result_o.valid  = 1'b1;
        state_d         = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    result_o.occupancy = OCC_W'(count_d);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      wr_off_q <= '0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      wr_off_q <= wr_off_d;
    end
  end

  // Element held during a move.
  always_ff @(posedge clk_i) begin
    moved_q <= moved_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ design/queue_move_nth_to_rear.sv @@
// Top level: bounded queue of signed words with a move-to-rear command.
//
//   Channel   Direction  Handshake             Payload
//   request   in         start && !busy        command_i, value_i, position_i
//   result    out        done_o (one cycle)    data_out_o, status_o, occupancy_o
//
// An enqueue, a refused request and a move that leaves the queue as it is are
// decided on acceptance; a dequeue first reads the memory. A move from position p
// reads that element, shifts each later one a slot lower and puts it at the rear,
// paced by the single write port of the entry memory, which moves one element per
// cycle. The result reaches the output register in the cycle after its last step.
// Reset empties the queue at once; memory contents are not cleared.
// The receiver cannot stall; busy holds new requests off during a move or dequeue.
module queue_move_nth_to_rear import qmr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic [POS_W-1:0]         position_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] data_out_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [OCC_W-1:0]         occupancy_o
);

  logic              accept;
  logic              ctrl_busy;
  mem_req_t          mem_req;
  result_t           result;
  logic [DATA_W-1:0] rdata;

  logic                     done_q;
  logic signed [DATA_W-1:0] data_q;
  status_e                  status_q;
  logic [OCC_W-1:0]         occ_q;

  assign accept = start && !ctrl_busy;
  assign busy   = ctrl_busy;

  // Sequencer.
  qmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (cmd_e'(command_i)),
    .value_i    (value_i),
    .position_i (position_i),
    .rdata_i    (rdata),
    .mem_req_o  (mem_req),
    .result_o   (result),
    .busy_o     (ctrl_busy)
  );

  // Entry memory.
  qmr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // Result strobe register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= result.valid;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (result.valid) begin
      data_q   <= result.data;
      status_q <= result.status;
      occ_q    <= result.occupancy;
    end
  end

  assign done_o      = done_q;
  assign data_out_o  = data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

  // An accepted enqueue always answers in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == CMD_ENQ) |=> done_o)
    else $error("enqueue result not returned in the next cycle");

  // The queue never reports more elements than it can hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= OCC_W'(DEPTH)))
    else $error("occupancy above queue depth");

  // A refused dequeue reports an empty queue and no data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (occupancy_o == '0 && data_out_o == '0))
    else $error("empty status with data or elements");

  // A refused enqueue only happens on a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (occupancy_o == OCC_W'(DEPTH)))
    else $error("full status on a queue that is not full");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the queue with move-to-rear: random and directed requests.
`timescale 1ns / 1ps

module testbench;
  import qmr_pkg::*;

  // Cycle limit for the whole run and cycles of quiet after the last result.
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_REQUESTS = 700;

  // One request waiting to be offered to the block.
  typedef struct {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    bit                       drain_first;
  } request_t;

  // One predicted result.
  typedef struct {
    logic signed [DATA_W-1:0] data;
    status_e                  status;
    logic [OCC_W-1:0]         occupancy;
  } queue_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         command_i = CMD_NOP;
  logic signed [DATA_W-1:0] value_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] data_out_o;
  logic [STAT_W-1:0]        status_o;
  logic [OCC_W-1:0]         occupancy_o;

  request_t                 pending_requests[$];
  queue_result_t            expected_results[$];
  request_t                 next_request;
  queue_result_t            seen_result;
  queue_result_t            wanted_result;
  logic signed [DATA_W-1:0] queue_words[DEPTH];
  int                       queue_count = 0;
  bit                       accepted_last = 1'b0;
  int                       issued_count = 0;
  int                       mismatches = 0;
  int                       cycle_count = 0;

  queue_move_nth_to_rear i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .command_i  (command_i),
    .value_i    (value_i),
    .position_i (position_i),
    .done_o     (done_o),
    .data_out_o (data_out_o),
    .status_o   (status_o),
    .occupancy_o(occupancy_o)
  );

  // Clock with a period of 2 ns.
  always #1 clk_i = ~clk_i;

  // Works out the result of one request and updates the shadow queue.
  function automatic queue_result_t apply_request(cmd_e cmd, logic signed [DATA_W-1:0] value,
                                                  logic [POS_W-1:0] position);
    queue_result_t            res;
    logic signed [DATA_W-1:0] moved;
    res.data = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_ENQ: begin
        if (queue_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          queue_words[queue_count] = value;
          queue_count++;
        end
      end
      CMD_DEQ: begin
        if (queue_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.data = queue_words[0];
          for (int i = 0; i + 1 < queue_count; i++) queue_words[i] = queue_words[i + 1];
          queue_count--;
        end
      end
      CMD_MOVE: begin
        if (position == 0 || position > queue_count) begin
          res.status = ST_RANGE;
        end else begin
          moved = queue_words[position - 1];
          for (int i = position - 1; i + 1 < queue_count; i++) begin
            queue_words[i] = queue_words[i + 1];
          end
          queue_words[queue_count - 1] = moved;
        end
      end
      default: ;
    endcase
    res.occupancy = queue_count[OCC_W-1:0];
    return res;
  endfunction

  // Appends one request to the list of pending requests.
  task automatic add_request(cmd_e cmd, logic signed [DATA_W-1:0] value,
                             logic [POS_W-1:0] position, bit drain_first = 1'b0);
    request_t req;
    req.cmd = cmd;
    req.value = value;
    req.position = position;
    req.drain_first = drain_first;
    pending_requests.push_back(req);
  endtask

  // Picks a random word, with the extremes now and then.
  function automatic logic signed [DATA_W-1:0] random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) return 32'sh8000_0000;
    if (pick < 8) return 32'sh7fff_ffff;
    if (pick < 10) return '0;
    return $urandom;
  endfunction

  // Picks a position, mostly a valid one, sometimes anything the field holds.
  function automatic logic [POS_W-1:0] random_position();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) return POS_W'($urandom_range(1, DEPTH));
    if (pick < 90) return POS_W'($urandom_range(0, 31));
    case ($urandom_range(0, 3))
      0: return 5'd0;
      1: return 5'd1;
      2: return POS_W'(DEPTH);
      default: return POS_W'(DEPTH + 1);
    endcase
  endfunction

  // Driver: offers requests at the falling edge and holds each one until it is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !accepted_last) begin
      // Still waiting for the block to take the current request.
    end else if (pending_requests.size() == 0 ||
                 (pending_requests[0].drain_first && expected_results.size() != 0) ||
                 (!(issued_count >= 250 && issued_count < 400) &&
                  $urandom_range(0, 99) < 37)) begin
      start <= 1'b0;
    end else begin
      next_request = pending_requests.pop_front();
      start <= 1'b1;
      command_i <= next_request.cmd;
      value_i <= next_request.value;
      position_i <= next_request.position;
      issued_count++;
    end
  end

  // Monitor: checks each result and predicts every request taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        seen_result.data = data_out_o;
        seen_result.status = status_e'(status_o);
        seen_result.occupancy = occupancy_o;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Result with no request outstanding: data %0d status %0d occupancy %0d",
                     seen_result.data, seen_result.status, seen_result.occupancy);
          end
        end else begin
          wanted_result = expected_results.pop_front();
          if (seen_result.data !== wanted_result.data ||
              seen_result.status !== wanted_result.status ||
              seen_result.occupancy !== wanted_result.occupancy) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected data %0d status %s occupancy %0d, got data %0d %s",
                       wanted_result.data, wanted_result.status.name(),
                       wanted_result.occupancy, seen_result.data,
                       $sformatf("status %0d occupancy %0d", status_o, occupancy_o));
            end
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_request(cmd_e'(command_i), value_i, position_i));
        accepted_last <= 1'b1;
      end else begin
        accepted_last <= 1'b0;
      end
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int enq_weight;
    int deq_weight;
    int pick;
    bit drain_now;

    // Directed part: the empty queue, the full queue and every edge of a move.
    add_request(CMD_DEQ, 32'sh1234_5678, 5'd3);
    add_request(CMD_MOVE, '0, 5'd1);
    add_request(CMD_NOP, 32'sh7fff_ffff, 5'd31);
    add_request(CMD_ENQ, 32'sh8000_0000, '0);
    add_request(CMD_ENQ, 32'sh7fff_ffff, 5'd31);
    add_request(CMD_ENQ, '0, '0);
    add_request(CMD_ENQ, -32'sd1, '0);
    for (int i = 4; i < DEPTH; i++) begin
      add_request(CMD_ENQ, $urandom, POS_W'($urandom_range(0, 31)));
    end
    add_request(CMD_ENQ, 32'sh5555_aaaa, '0);
    add_request(CMD_MOVE, '0, 5'd1);
    add_request(CMD_MOVE, '0, POS_W'(DEPTH));
    add_request(CMD_MOVE, '0, POS_W'(DEPTH + 1));
    add_request(CMD_MOVE, '0, 5'd31);
    add_request(CMD_MOVE, '0, 5'd0);
    add_request(CMD_MOVE, -32'sd1, 5'd7);
    add_request(CMD_DEQ, '0, '0);

    // Random part in blocks that fill, empty or churn the queue.
    for (int blk = 0; blk * 40 < RANDOM_REQUESTS; blk++) begin
      case ($urandom_range(0, 2))
        0: begin enq_weight = 70; deq_weight = 10; end
        1: begin enq_weight = 15; deq_weight = 60; end
        default: begin enq_weight = 35; deq_weight = 30; end
      endcase
      for (int i = 0; i < 40; i++) begin
        drain_now = (i == 0 && blk % 3 == 0);
        pick = $urandom_range(0, 99);
        if (pick < enq_weight) begin
          add_request(CMD_ENQ, random_word(), POS_W'($urandom_range(0, 31)), drain_now);
        end else if (pick < enq_weight + deq_weight) begin
          add_request(CMD_DEQ, $urandom, POS_W'($urandom_range(0, 31)), drain_now);
        end else if (pick < 97) begin
          add_request(CMD_MOVE, $urandom, random_position(), drain_now);
        end else begin
          add_request(CMD_NOP, $urandom, POS_W'($urandom_range(0, 31)), drain_now);
        end
      end
    end

    // Hold reset, then release it at a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to be taken and every result to arrive.
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
